### src/ibe_pkg.sv
// Shared types and codes for the byte-level I2C master engine.
// No dependencies; imported by every module of the block.
package ibe_pkg;

	localparam int CmdW   = 3;
	localparam int PhaseW = 4;
	localparam int CountW = 4;
	localparam int TickW  = 8;
	localparam int ByteW  = 8;
	localparam int InW    = 16;
	localparam int OutW   = 16;

	localparam logic [PhaseW-1:0] PH_IDLE = 4'd0;
	localparam logic [PhaseW-1:0] PH_S1   = 4'd1;
	localparam logic [PhaseW-1:0] PH_S2   = 4'd2;
	localparam logic [PhaseW-1:0] PH_S3   = 4'd3;
	localparam logic [PhaseW-1:0] PH_P1   = 4'd4;
	localparam logic [PhaseW-1:0] PH_P2   = 4'd5;
	localparam logic [PhaseW-1:0] PH_DL   = 4'd6;
	localparam logic [PhaseW-1:0] PH_DH   = 4'd7;
	localparam logic [PhaseW-1:0] PH_AL   = 4'd8;
	localparam logic [PhaseW-1:0] PH_AH   = 4'd9;

	localparam logic [CmdW-1:0] OP_NONE  = 3'd0;
	localparam logic [CmdW-1:0] OP_START = 3'd1;
	localparam logic [CmdW-1:0] OP_STOP  = 3'd2;
	localparam logic [CmdW-1:0] OP_WRITE = 3'd3;
	localparam logic [CmdW-1:0] OP_READ  = 3'd4;

	localparam logic [TickW-1:0]  PHASE_TICKS_RST = 8'd3;
	localparam logic [ByteW-1:0]  MSB_MASK        = 8'h80;
	localparam logic [CountW-1:0] BITS_PER_BYTE   = 4'd8;

	typedef struct packed {
		logic [CmdW-1:0]  cmd;
		logic [ByteW-1:0] tx_byte;
		logic             ack_level;
		logic             sda_in;
	} item_t;

	typedef struct packed {
		logic             scl;
		logic             sda_low;
		logic             busy_res;
		logic             done_res;
		logic [ByteW-1:0] rx_byte;
		logic             ack_seen;
	} result_t;

endpackage

### src/ibe_seq.sv
// Bus phase sequencer: state registers and one-tick next-state logic.
// Depends on ibe_pkg.
module ibe_seq
	import ibe_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  item_t            item,
	input  logic [TickW-1:0] phase_ticks,
	output result_t          res
);

	logic [PhaseW-1:0] phase_q, phase_n;
	logic [CountW-1:0] bit_q, bit_n;
	logic [TickW-1:0]  tick_q, tick_n;
	logic [ByteW-1:0]  shift_q, shift_n;
	logic [ByteW-1:0]  rx_q, rx_n;
	logic              ack_q, ack_n;
	logic              scl_q, scl_n;
	logic              sda_q, sda_n;
	logic [CmdW-1:0]   op_q, op_n;
	logic              ackdrv_q, ackdrv_n;
	logic              sample_q, sample_n;
	logic              done;
	logic              wr;
	logic [TickW-1:0]  pt;

	assign wr = (op_q == OP_WRITE);
	assign pt = (phase_ticks == '0) ? TickW'(1) : phase_ticks;

	always_comb begin
		phase_n  = phase_q;
		bit_n    = bit_q;
		tick_n   = tick_q;
		shift_n  = shift_q;
		rx_n     = rx_q;
		ack_n    = ack_q;
		scl_n    = scl_q;
		sda_n    = sda_q;
		op_n     = op_q;
		ackdrv_n = ackdrv_q;
		sample_n = sample_q;
		done     = 1'b0;
		if (phase_q == PH_IDLE) begin
			tick_n = '0;
			bit_n  = '0;
			unique case (item.cmd)
				OP_START: begin
					op_n = item.cmd; scl_n = 1'b1; sda_n = 1'b0; phase_n = PH_S1;
				end
				OP_STOP: begin
					op_n = item.cmd; scl_n = 1'b0; sda_n = 1'b1; phase_n = PH_P1;
				end
				OP_WRITE: begin
					op_n    = item.cmd;
					shift_n = item.tx_byte;
					scl_n   = 1'b0;
					sda_n   = ((item.tx_byte & MSB_MASK) == '0);
					phase_n = PH_DL;
				end
				OP_READ: begin
					op_n     = item.cmd;
					shift_n  = '0;
					ackdrv_n = item.ack_level;
					scl_n    = 1'b0;
					sda_n    = 1'b0;
					phase_n  = PH_DL;
				end
				default: ;
			endcase
		end else begin
			if ((phase_q == PH_DH && op_q == OP_READ) || (phase_q == PH_AH && wr))
				sample_n = item.sda_in;
			tick_n = tick_q + TickW'(1);
			if (tick_n >= pt) begin
				tick_n = '0;
				unique case (phase_q)
					PH_S1: begin scl_n = 1'b1; sda_n = 1'b1; phase_n = PH_S2; end
					PH_S2: begin scl_n = 1'b0; sda_n = 1'b1; phase_n = PH_S3; end
					PH_S3: begin phase_n = PH_IDLE; done = 1'b1; end
					PH_P1: begin scl_n = 1'b1; sda_n = 1'b1; phase_n = PH_P2; end
					PH_P2: begin
						scl_n = 1'b1; sda_n = 1'b0; phase_n = PH_IDLE; done = 1'b1;
					end
					PH_DL: begin scl_n = 1'b1; phase_n = PH_DH; end
					PH_DH: begin
						shift_n = wr ? {shift_q[ByteW-2:0], 1'b0}
						             : {shift_q[ByteW-2:0], sample_n};
						bit_n = bit_q + CountW'(1);
						scl_n = 1'b0;
						if (bit_n >= BITS_PER_BYTE) begin
							if (!wr)
								rx_n = shift_n;
							sda_n   = wr ? 1'b0 : ~ackdrv_q;
							phase_n = PH_AL;
						end else begin
							sda_n   = wr ? ((shift_n & MSB_MASK) == '0) : 1'b0;
							phase_n = PH_DL;
						end
					end
					PH_AL: begin scl_n = 1'b1; phase_n = PH_AH; end
					PH_AH: begin
						if (wr) begin
							ack_n = ~sample_n;
							sda_n = 1'b0;
						end
						scl_n   = 1'b0;
						phase_n = PH_IDLE;
						done    = 1'b1;
					end
					default: begin phase_n = PH_IDLE; done = 1'b1; end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			bit_q    <= '0;
			tick_q   <= '0;
			shift_q  <= '0;
			rx_q     <= '0;
			ack_q    <= 1'b0;
			scl_q    <= 1'b1;
			sda_q    <= 1'b0;
			op_q     <= OP_NONE;
			ackdrv_q <= 1'b0;
			sample_q <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_n;
			bit_q    <= bit_n;
			tick_q   <= tick_n;
			shift_q  <= shift_n;
			rx_q     <= rx_n;
			ack_q    <= ack_n;
			scl_q    <= scl_n;
			sda_q    <= sda_n;
			op_q     <= op_n;
			ackdrv_q <= ackdrv_n;
			sample_q <= sample_n;
		end
	end

	always_comb begin
		res.scl      = scl_n;
		res.sda_low  = sda_n;
		res.busy_res = (phase_n != PH_IDLE);
		res.done_res = done;
		res.rx_byte  = rx_n;
		res.ack_seen = ack_n;
	end

endmodule

### src/ibe_out.sv
// Result register of the engine: holds one item until the receiver takes it.
// Depends on ibe_pkg.
module ibe_out
	import ibe_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  result_t         res,
	input  logic            take,
	output logic            valid,
	output logic [OutW-1:0] data
);

	logic            valid_q;
	logic [OutW-1:0] data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (load)
			valid_q <= 1'b1;
		else if (take)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load)
			data_q <= {3'b000, res.ack_seen, res.rx_byte, res.done_res, res.busy_res,
			           res.sda_low, res.scl};
	end

	assign valid = valid_q;
	assign data  = data_q;

endmodule

### src/i2c_master_byte_engine.sv
// Byte-level I2C master engine, top level.
// Holds the phase length register; uses ibe_pkg, ibe_seq and ibe_out.
//
// Each input item on the s_axis channel is one timing tick. It carries a
// command (start, stop, write byte, read byte), taken only while idle, plus
// the byte to send, the ACK/NACK level for a read and the sampled SDA level.
// Every accepted item yields exactly one result item on m_axis: the SCL level,
// the SDA pull-low enable, busy, a done pulse, the last received byte and the
// acknowledge seen after the last write.
// The result of an accepted item is formed combinationally and captured in the output register on acceptance.
// Throughput: one item per clock while the output is not stalled; the tick logic is a single registered pass.
// A stalled receiver holds the result; s_axis_tready stays high while the
// output register is empty or being taken in the same cycle.
// cfg_wen writes phase_ticks (SCL phase length in ticks, zero acts as one).
// Reset (arst_n low) returns to idle with SCL released high, SDA released,
// phase_ticks at 3 and the output register empty.
module i2c_master_byte_engine
	import ibe_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wen,
	input  logic [TickW-1:0] cfg_wdata,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// cmd[2:0], tx_byte[10:3], ack_level[11], sda_in[12], zero[15:13]
	input  logic [InW-1:0]   s_axis_tdata,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// scl[0], sda_low[1], busy_res[2], done_res[3], rx_byte[11:4], ack_seen[12], zero[15:13]
	output logic [OutW-1:0]  m_axis_tdata
);

	logic [TickW-1:0] ptick_q;
	logic             step;
	item_t            item;
	result_t          res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ptick_q <= PHASE_TICKS_RST;
		else if (cfg_wen)
			ptick_q <= cfg_wdata;
	end

	assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
	assign step          = s_axis_tvalid && s_axis_tready;

	assign item.cmd       = s_axis_tdata[2:0];
	assign item.tx_byte   = s_axis_tdata[10:3];
	assign item.ack_level = s_axis_tdata[11];
	assign item.sda_in    = s_axis_tdata[12];

	ibe_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.item        (item),
		.phase_ticks (ptick_q),
		.res         (res)
	);

	ibe_out u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (step),
		.res    (res),
		.take   (m_axis_tready),
		.valid  (m_axis_tvalid),
		.data   (m_axis_tdata)
	);

endmodule
